FILE: design/spq_pkg.sv
package spq_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OCC_W    = 7;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    typedef struct packed {
        logic [31:0] value;
        logic [31:0] prio;
    } t_entry;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] item_value;
        logic signed [31:0] item_priority;
    } t_item;

    typedef struct packed {
        logic signed [31:0] removed_value;
        logic               was_empty;
        logic               insert_dropped;
        logic [OCC_W-1:0]   occupancy;
    } t_result;

    // Broadcast to every cell of the row in the cycle an item is taken.
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_entry new_entry;
    } t_cell_ctl;

endpackage

FILE: design/spq_cell.sv
module spq_cell (
    input  logic               i_clk,
    input  spq_pkg::t_cell_ctl i_ctl,
    input  logic               i_in_range,
    input  spq_pkg::t_entry    i_prev,
    input  logic               i_prev_keep,
    input  spq_pkg::t_entry    i_next,
    output spq_pkg::t_entry    o_entry,
    output logic               o_keep
);

    spq_pkg::t_entry r_entry;
    spq_pkg::t_entry n_entry;

    // A held entry stays put only if the new entry sorts strictly behind it,
    // so a new entry goes ahead of all held entries of equal priority.
    assign o_keep = i_in_range &&
                    ($signed(i_ctl.new_entry.prio) > $signed(r_entry.prio));

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins) begin
            if (!o_keep) begin
                if (i_prev_keep) begin
                    n_entry = i_ctl.new_entry;
                end else begin
                    n_entry = i_prev;
                end
            end
        end else if (i_ctl.rem) begin
            n_entry = i_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

FILE: design/sorted_priority_queue.sv
// Sorted priority queue held in a row of cells, front entry in cell 0.
// Input: one beat is taken at a rising edge where start is high and busy is
// low. A beat with mode insert places (item_value, item_priority) before the
// first held entry of equal or greater priority; a beat with mode remove
// takes out the front entry, the smallest priority and newest among equals.
// Output: every accepted beat gives exactly one result beat on o_result,
// marked by o_valid for one cycle, in the cycle after the beat is taken.
// There is no hold-off on the result side; the receiver must take it then.
// Throughput is one beat per cycle while busy is low: each cell compares its
// own entry with the broadcast new entry and loads from itself, the new entry
// or a neighbor in that same cycle, so no operation ripples down the row.
// Busy is high only while reset is held. Reset (synchronous, active low)
// empties the queue and clears o_valid; the cell contents are left as they
// are and become meaningless once the count is zero.
// A remove on an empty queue returns 0 with was_empty set; an insert into a
// full queue is dropped with insert_dropped set. occupancy gives the low
// seven bits of the entry count after the beat.
module sorted_priority_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  spq_pkg::t_item   i_item,
    output logic             o_valid,
    output spq_pkg::t_result o_result
);

    logic                      accept;
    logic                      full;
    logic                      empty;
    spq_pkg::t_cell_ctl        ctl;
    logic [spq_pkg::CNT_W-1:0] r_count;
    logic [spq_pkg::CNT_W-1:0] n_count;
    logic                      r_valid;
    spq_pkg::t_result          r_result;
    spq_pkg::t_result          n_result;
    spq_pkg::t_entry           cell_entry [spq_pkg::CAPACITY];
    logic                      cell_keep  [spq_pkg::CAPACITY];

    assign busy   = !i_rst_n;
    assign accept = start && !busy;
    assign full   = (r_count == spq_pkg::CNT_W'(spq_pkg::CAPACITY));
    assign empty  = (r_count == '0);

    always_comb begin
        ctl.ins             = accept && (i_item.mode == spq_pkg::MODE_INSERT) && !full;
        ctl.rem             = accept && (i_item.mode == spq_pkg::MODE_REMOVE) && !empty;
        ctl.new_entry.value = i_item.item_value;
        ctl.new_entry.prio  = i_item.item_priority;
    end

    for (genvar gi = 0; gi < spq_pkg::CAPACITY; gi++) begin : g_cell
        spq_pkg::t_entry prev_entry;
        spq_pkg::t_entry next_entry;
        logic            prev_keep;
        logic            in_range;

        assign in_range = (spq_pkg::CNT_W'(gi) < r_count);

        if (gi == 0) begin : g_head
            assign prev_entry = ctl.new_entry;
            assign prev_keep  = 1'b1;
        end else begin : g_body
            assign prev_entry = cell_entry[gi-1];
            assign prev_keep  = cell_keep[gi-1];
        end

        if (gi == spq_pkg::CAPACITY - 1) begin : g_tail
            assign next_entry = '0;
        end else begin : g_link
            assign next_entry = cell_entry[gi+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl),
            .i_in_range  (in_range),
            .i_prev      (prev_entry),
            .i_prev_keep (prev_keep),
            .i_next      (next_entry),
            .o_entry     (cell_entry[gi]),
            .o_keep      (cell_keep[gi])
        );
    end

    always_comb begin
        n_count = r_count;
        if (ctl.ins) begin
            n_count = r_count + 1'b1;
        end else if (ctl.rem) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        n_result.removed_value  = ctl.rem ? cell_entry[0].value : 32'sd0;
        n_result.was_empty      = accept && (i_item.mode == spq_pkg::MODE_REMOVE) && empty;
        n_result.insert_dropped = accept && (i_item.mode == spq_pkg::MODE_INSERT) && full;
        n_result.occupancy      = spq_pkg::OCC_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

FILE: design/spq_checker.sv
module spq_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input spq_pkg::t_item   i_item,
    input logic             o_valid,
    input spq_pkg::t_result o_result
);

    // Every accepted beat gives its result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("accepted beat without a result in the next cycle");

    // No result appears without a beat taken the cycle before.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_valid)
        else $error("result without an accepted beat");

    // An empty remove returns zero and leaves the queue empty.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.was_empty) |->
            (o_result.removed_value == 32'sd0) && (o_result.occupancy == '0)
            && !o_result.insert_dropped)
        else $error("empty remove with bad result");

    // A dropped insert means the queue stays full.
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.insert_dropped) |->
            (o_result.occupancy == spq_pkg::OCC_W'(spq_pkg::CAPACITY))
            && (o_result.removed_value == 32'sd0))
        else $error("dropped insert with bad result");

    // An insert never returns a value.
    a_insert_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_item.mode == spq_pkg::MODE_INSERT)) |=>
            (o_result.removed_value == 32'sd0))
        else $error("insert returned a value");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .o_result (o_result)
);

FILE: bench/tb_sorted_priority_queue.sv
`timescale 1ns / 100ps

module tb_sorted_priority_queue;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_BEATS   = 1830;
    localparam int IDLE_PCT       = 34;
    localparam int NO_IDLE_FIRST  = 700;
    localparam int NO_IDLE_LAST   = 1000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int STALL_LIMIT    = 2000;

    typedef enum logic [1:0] {PH_FILL, PH_DRAIN, PH_MIX} t_phase;

    typedef struct {
        spq_pkg::t_item   item;
        bit               typed;
        spq_pkg::t_result want;
    } t_row;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start   = 1'b0;
    spq_pkg::t_item   i_item  = '0;
    logic             busy;
    logic             o_valid;
    spq_pkg::t_result o_result;

    // Shadow copy of the queue contents, front entry at index 0.
    spq_pkg::t_entry  held_entries[$];
    spq_pkg::t_result expected_results[$];
    t_row             directed_rows[$];

    int mismatch_count = 0;
    int stall_cycles   = 0;
    int idle_pct       = IDLE_PCT;
    int n_insert = 0, n_dropped = 0, n_remove = 0, n_empty = 0, peak_occ = 0;

    sorted_priority_queue DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        forever #HALF_PERIOD i_clk = ~i_clk;
    end

    function automatic spq_pkg::t_result result_of(logic [31:0] val, logic empty,
                                                   logic dropped,
                                                   logic [spq_pkg::OCC_W-1:0] occ);
        spq_pkg::t_result r;
        r.removed_value  = val;
        r.was_empty      = empty;
        r.insert_dropped = dropped;
        r.occupancy      = occ;
        return r;
    endfunction

    // Applies one beat to the shadow queue and returns the result it gives.
    function automatic spq_pkg::t_result predict_queue_beat(spq_pkg::t_item it);
        spq_pkg::t_result r;
        spq_pkg::t_entry  e;
        int               pos;
        r = '0;
        if (it.mode == spq_pkg::MODE_INSERT) begin
            n_insert++;
            if (held_entries.size() >= spq_pkg::CAPACITY) begin
                r.insert_dropped = 1'b1;
                n_dropped++;
            end else begin
                pos = 0;
                while (pos < held_entries.size() &&
                       $signed(held_entries[pos].prio) < it.item_priority)
                    pos++;
                e.value = it.item_value;
                e.prio  = it.item_priority;
                held_entries.insert(pos, e);
            end
        end else begin
            n_remove++;
            if (held_entries.size() == 0) begin
                r.was_empty = 1'b1;
                n_empty++;
            end else begin
                r.removed_value = held_entries[0].value;
                held_entries.pop_front();
            end
        end
        r.occupancy = spq_pkg::OCC_W'(held_entries.size());
        if (held_entries.size() > peak_occ)
            peak_occ = held_entries.size();
        return r;
    endfunction

    function automatic void add_row(logic mode, logic [31:0] val, logic [31:0] prio,
                                    bit typed, spq_pkg::t_result want);
        t_row row;
        row.item.mode          = mode;
        row.item.item_value    = val;
        row.item.item_priority = prio;
        row.typed              = typed;
        row.want               = want;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [31:0] pick_priority();
        int sel;
        sel = $urandom_range(99);
        if (sel < 40)
            return 32'($signed($urandom_range(4)) - 2);
        else if (sel < 60) begin
            case ($urandom_range(3))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    function automatic spq_pkg::t_item make_beat(t_phase phase);
        spq_pkg::t_item it;
        int             insert_pct;
        case (phase)
            PH_FILL:  insert_pct = 85;
            PH_DRAIN: insert_pct = 15;
            default:  insert_pct = 50;
        endcase
        it.mode          = ($urandom_range(99) < insert_pct) ? spq_pkg::MODE_INSERT
                                                             : spq_pkg::MODE_REMOVE;
        it.item_value    = $urandom;
        it.item_priority = pick_priority();
        return it;
    endfunction

    // Holds the beat on the port until it is taken, then records what it should give.
    task automatic drive_beat(spq_pkg::t_item it, bit typed, spq_pkg::t_result want);
        spq_pkg::t_result predicted;
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        predicted = predict_queue_beat(it);
        expected_results.push_back(typed ? want : predicted);
    endtask

    // Each cycle is left idle with the given chance, so idle cycles make up that share.
    task automatic maybe_idle();
        while ($urandom_range(99) < idle_pct) begin
            start  <= 1'b0;
            i_item <= {1'($urandom), $urandom, $urandom};
            @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do @(posedge i_clk); while (expected_results.size() != 0);
    endtask

    always @(posedge i_clk) begin
        spq_pkg::t_result want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("result beat with no expectation pending: %p", o_result);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_result.removed_value !== want.removed_value) begin
                    $error("removed_value: expected %0d, actual %0d",
                           want.removed_value, o_result.removed_value);
                    mismatch_count++;
                end
                if (o_result.was_empty !== want.was_empty) begin
                    $error("was_empty: expected %0b, actual %0b",
                           want.was_empty, o_result.was_empty);
                    mismatch_count++;
                end
                if (o_result.insert_dropped !== want.insert_dropped) begin
                    $error("insert_dropped: expected %0b, actual %0b",
                           want.insert_dropped, o_result.insert_dropped);
                    mismatch_count++;
                end
                if (o_result.occupancy !== want.occupancy) begin
                    $error("occupancy: expected %0d, actual %0d",
                           want.occupancy, o_result.occupancy);
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run if neither side moves a beat for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_phase phase;
        int     sent_random;
        int     phase_len;

        // Directed beats: empty queue, extremes of value and priority, ties, junk on remove.
        add_row(spq_pkg::MODE_REMOVE, 32'h1234_5678, 32'hFFFF_0000, 1'b1,
                result_of(32'h0, 1'b1, 1'b0, spq_pkg::OCC_W'(0)));
        add_row(spq_pkg::MODE_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1,
                result_of(32'h0, 1'b0, 1'b0, spq_pkg::OCC_W'(1)));
        add_row(spq_pkg::MODE_INSERT, 32'h8000_0000, 32'h8000_0000, 1'b1,
                result_of(32'h0, 1'b0, 1'b0, spq_pkg::OCC_W'(2)));
        add_row(spq_pkg::MODE_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1,
                result_of(32'h0, 1'b0, 1'b0, spq_pkg::OCC_W'(3)));
        add_row(spq_pkg::MODE_INSERT, 32'h0000_0005, 32'h0000_0000, 1'b1,
                result_of(32'h0, 1'b0, 1'b0, spq_pkg::OCC_W'(4)));
        add_row(spq_pkg::MODE_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
                result_of(32'h8000_0000, 1'b0, 1'b0, spq_pkg::OCC_W'(3)));
        add_row(spq_pkg::MODE_REMOVE, 32'h0, 32'h0, 1'b0, '0);
        add_row(spq_pkg::MODE_REMOVE, 32'h0, 32'h0, 1'b0, '0);
        add_row(spq_pkg::MODE_REMOVE, 32'h0, 32'h0, 1'b0, '0);
        add_row(spq_pkg::MODE_REMOVE, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1,
                result_of(32'h0, 1'b1, 1'b0, spq_pkg::OCC_W'(0)));
        add_row(spq_pkg::MODE_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0);
        add_row(spq_pkg::MODE_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0);
        add_row(spq_pkg::MODE_INSERT, 32'h0000_0001, 32'h5555_5555, 1'b0, '0);
        add_row(spq_pkg::MODE_INSERT, 32'h0000_0002, 32'h8000_0000, 1'b0, '0);
        add_row(spq_pkg::MODE_INSERT, 32'h0000_0003, 32'h7FFF_FFFF, 1'b0, '0);
        repeat (6) add_row(spq_pkg::MODE_REMOVE, 32'h0, 32'h0, 1'b0, '0);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            drive_beat(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
            maybe_idle();
        end

        // Random part in phases that push the queue to full, back to empty, or hold it mid-way.
        // Inside the stretch without idling the phases follow each other without a drain.
        sent_random = 0;
        while (sent_random < RANDOM_BEATS) begin
            if (sent_random < NO_IDLE_FIRST || sent_random >= NO_IDLE_LAST)
                wait_drained();
            phase     = t_phase'($urandom_range(2));
            phase_len = $urandom_range(60, 180);
            for (int k = 0; k < phase_len && sent_random < RANDOM_BEATS; k++) begin
                idle_pct = (sent_random >= NO_IDLE_FIRST && sent_random < NO_IDLE_LAST) ?
                           0 : IDLE_PCT;
                drive_beat(make_beat(phase), 1'b0, '0);
                sent_random++;
                maybe_idle();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d inserts (%0d dropped on a full queue) and %0d removes",
                 n_insert, n_dropped, n_remove);
        $display("(%0d on an empty queue); peak occupancy %0d of %0d.",
                 n_empty, peak_occ, spq_pkg::CAPACITY);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: sim.f
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
design/spq_checker.sv
bench/tb_sorted_priority_queue.sv
